@@ src/crs_pkg.sv @@
// Shared types and constants for the clip region subtract block.
`timescale 1ns / 1ps

package crs_pkg;

    localparam int COORD_W = 16;
    localparam int COUNT_W = 7;
    localparam int NBANDS  = 4;

    // Band positions in the band mask, in output order
    localparam int BAND_TOP    = 0;
    localparam int BAND_BOTTOM = 1;
    localparam int BAND_LEFT   = 2;
    localparam int BAND_RIGHT  = 3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        JOB_PASS,
        JOB_BANDS,
        JOB_COVERED
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [NBANDS-1:0]   bands;
        logic [COUNT_W-1:0]  count;
        coord_t              rl;
        coord_t              rt;
        coord_t              rr;
        coord_t              rb;
        coord_t              cl;
        coord_t              ct;
        coord_t              cr;
        coord_t              cb;
    } job_t;

endpackage

@@ src/crs_front.sv @@
// Front end: takes rectangles, classifies them against the clip, tracks region state.
`timescale 1ns / 1ps

module crs_front import crs_pkg::*; #(
    parameter int REGION_CAP = 64
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t rect_left,
    input  coord_t rect_top,
    input  coord_t rect_right,
    input  coord_t rect_bottom,
    input  coord_t clip_left,
    input  coord_t clip_top,
    input  coord_t clip_right,
    input  coord_t clip_bottom,
    input  logic   region_last,
    output logic   push,
    output job_t   push_job,
    input  logic   queue_full
);

    localparam int CNT_W = $clog2(REGION_CAP + 1);

    logic             any_kept_reg, any_kept_next;
    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic             accept;
    coord_t           il, it, ir, ib;
    logic             hit;
    logic [NBANDS-1:0] bands;
    logic             emits;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        il = (rect_left  > clip_left)   ? rect_left   : clip_left;
        it = (rect_top   > clip_top)    ? rect_top    : clip_top;
        ir = (rect_right < clip_right)  ? rect_right  : clip_right;
        ib = (rect_bottom < clip_bottom) ? rect_bottom : clip_bottom;
        hit = (il < ir) && (it < ib);
        bands[BAND_TOP]    = clip_top > rect_top;
        bands[BAND_BOTTOM] = clip_bottom < rect_bottom;
        bands[BAND_LEFT]   = clip_left > rect_left;
        bands[BAND_RIGHT]  = clip_right < rect_right;
        count_inc = (count_reg < CNT_W'(REGION_CAP)) ? count_reg + 1'b1 : count_reg;
        emits = !hit || (bands != '0);
    end

    always_comb begin
        push_job.rl    = rect_left;
        push_job.rt    = rect_top;
        push_job.rr    = rect_right;
        push_job.rb    = rect_bottom;
        push_job.cl    = clip_left;
        push_job.ct    = clip_top;
        push_job.cr    = clip_right;
        push_job.cb    = clip_bottom;
        push_job.bands = bands;
        push_job.count = COUNT_W'(count_inc);
        if (!hit) begin
            push_job.kind = JOB_PASS;
        end else if (bands != '0) begin
            push_job.kind = JOB_BANDS;
        end else begin
            push_job.kind = JOB_COVERED;
        end
        // fully covered rectangles only emit when they close an empty region
        push = accept && (emits || (region_last && !any_kept_reg));
    end

    always_comb begin
        any_kept_next = any_kept_reg;
        count_next    = count_reg;
        if (accept) begin
            if (region_last) begin
                any_kept_next = 1'b0;
                count_next    = '0;
            end else begin
                any_kept_next = any_kept_reg || emits;
                count_next    = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_kept_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            any_kept_reg <= any_kept_next;
            count_reg    <= count_next;
        end
    end

endmodule

@@ src/crs_queue.sv @@
// Short job queue between the front end and the band generator.
`timescale 1ns / 1ps

module crs_queue import crs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = fill_reg == CNT_W'(DEPTH);
    assign empty   = fill_reg == '0;
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/crs_back.sv @@
// Back end: walks each queued job and emits one rectangle per cycle while out_ready allows.
`timescale 1ns / 1ps

module crs_back import crs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    input  job_t               head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output coord_t             out_left,
    output coord_t             out_top,
    output coord_t             out_right,
    output coord_t             out_bottom,
    output logic               run_last,
    output logic               all_covered,
    output logic [COUNT_W-1:0] covered_count
);

    logic [NBANDS-1:0]  done_reg, done_next, pending, sel;
    logic               valid_reg, valid_next;
    coord_t             l_reg, t_reg, r_reg, b_reg;
    coord_t             l_next, t_next, r_next, b_next;
    logic               last_reg, last_next;
    logic               cov_reg, cov_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               load;

    // output register free or being drained this cycle
    assign load    = !empty && (!valid_reg || out_ready);
    assign pending = head.bands & ~done_reg;

    always_comb begin
        sel      = '0;
        l_next   = head.rl;
        t_next   = head.rt;
        r_next   = head.rr;
        b_next   = head.rb;
        last_next = 1'b1;
        cov_next = 1'b0;
        cnt_next = '0;
        case (head.kind)
            JOB_PASS: begin
            end
            JOB_COVERED: begin
                l_next   = '0;
                t_next   = '0;
                r_next   = '0;
                b_next   = '0;
                cov_next = 1'b1;
                cnt_next = head.count;
            end
            JOB_BANDS: begin
                if (pending[BAND_TOP]) begin
                    sel[BAND_TOP] = 1'b1;
                    b_next        = head.ct;
                    last_next     = pending[NBANDS-1:BAND_TOP+1] == '0;
                end else if (pending[BAND_BOTTOM]) begin
                    sel[BAND_BOTTOM] = 1'b1;
                    t_next           = head.cb;
                    last_next        = pending[NBANDS-1:BAND_BOTTOM+1] == '0;
                end else if (pending[BAND_LEFT]) begin
                    sel[BAND_LEFT] = 1'b1;
                    r_next         = head.cl;
                    last_next      = !pending[BAND_RIGHT];
                end else begin
                    sel[BAND_RIGHT] = 1'b1;
                    l_next          = head.cr;
                end
            end
            default: begin
            end
        endcase
    end

    assign pop = load && last_next;

    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            done_next  = last_next ? '0 : (done_reg | sel);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            l_reg    <= l_next;
            t_reg    <= t_next;
            r_reg    <= r_next;
            b_reg    <= b_next;
            last_reg <= last_next;
            cov_reg  <= cov_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_left      = l_reg;
    assign out_top       = t_reg;
    assign out_right     = r_reg;
    assign out_bottom    = b_reg;
    assign run_last      = last_reg;
    assign all_covered   = cov_reg;
    assign covered_count = cnt_reg;

endmodule

@@ src/clip_region_subtract.sv @@
// Top level of the clip region subtract block.
`timescale 1ns / 1ps
//
// Subtracts a clip rectangle from a region streamed one rectangle per
// transaction on the s_axis side; s_axis_tlast marks the region's final one.
// Each rectangle yields on m_axis either itself (no overlap with the clip),
// up to four bands in the order top, bottom, left, right, or nothing (fully
// covered). A region that is covered throughout ends with one transaction
// carrying all_covered and the rectangle count (saturating at REGION_CAP).
// m_axis_tlast marks the last result caused by one input transaction.
//
// A result passes through the job queue and then the band generator's output
// register. Throughput: one result per cycle while jobs are queued and
// m_axis_tready is high; an input causes 0 to 4 results, which all leave by
// the single result register of the band generator. The classifier takes one
// input per cycle while the job queue (QUEUE_DEPTH entries) has room, so a
// stalled m_axis fills the queue and only then drops s_axis_tready.
// Reset (aresetn low, synchronous) empties the queue and the output register
// and clears the region state: the next rectangle starts a fresh region.
//
module clip_region_subtract import crs_pkg::*; #(
    parameter int REGION_CAP  = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    // rect_left, rect_top, rect_right, rect_bottom,
    // clip_left, clip_top, clip_right, clip_bottom (16 bits each, low first)
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // region_last
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // out_left, out_top, out_right, out_bottom (16 bits each, low first)
    output logic [63:0]  m_axis_tdata,
    // all_covered [0], covered_count [7:1]
    output logic [7:0]   m_axis_tuser,
    output logic         m_axis_tlast,   // run_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);

    logic               push, full, pop, empty;
    job_t               push_job, head;
    coord_t             o_l, o_t, o_r, o_b;
    logic               o_cov;
    logic [COUNT_W-1:0] o_cnt;

    crs_front #(
        .REGION_CAP(REGION_CAP)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .rect_left   (s_axis_tdata[15:0]),
        .rect_top    (s_axis_tdata[31:16]),
        .rect_right  (s_axis_tdata[47:32]),
        .rect_bottom (s_axis_tdata[63:48]),
        .clip_left   (s_axis_tdata[79:64]),
        .clip_top    (s_axis_tdata[95:80]),
        .clip_right  (s_axis_tdata[111:96]),
        .clip_bottom (s_axis_tdata[127:112]),
        .region_last (s_axis_tlast),
        .push        (push),
        .push_job    (push_job),
        .queue_full  (full)
    );

    crs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    crs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .empty         (empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_left      (o_l),
        .out_top       (o_t),
        .out_right     (o_r),
        .out_bottom    (o_b),
        .run_last      (m_axis_tlast),
        .all_covered   (o_cov),
        .covered_count (o_cnt)
    );

    assign m_axis_tdata = {o_b, o_r, o_t, o_l};
    assign m_axis_tuser = {o_cnt, o_cov};

endmodule
